// File: rtl/core/rfcm_pkg.sv
// shared types, constants and width helpers for the rotate-fit coordinate mapper
`timescale 1ns / 1ps

package rfcm_pkg;

    localparam int COORD_W       = 24;
    localparam int DEF_FRAC_BITS = 8;
    localparam int DEF_DIM_BITS  = 12;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NATIVE_WIDTH   = 3'd0,
        REG_NATIVE_HEIGHT  = 3'd1,
        REG_VIDEO_WIDTH    = 3'd2,
        REG_VIDEO_HEIGHT   = 3'd3,
        REG_QUARTER_TURNS  = 3'd4,
        REG_CROP_MODE      = 3'd5,
        REG_TRIM_TOLERANCE = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic {
        CMD_TO_NATIVE = 1'b0,
        CMD_TO_VIDEO  = 1'b1
    } cmd_t;

    // control that rides along with an item through the divider
    typedef struct packed {
        cmd_t cmd;
        logic neg_x;
        logic neg_y;
    } tag_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // signed width of a rotated coordinate before scaling
    function automatic int rot_width(input int dim, input int frac);
        return max_int(COORD_W, dim + frac + 1) + 2;
    endfunction

    // signed width of the rounding dividend
    function automatic int dvd_width(input int dim, input int frac);
        return max_int(rot_width(dim, frac) + dim + 2, 2 * dim + 1 + frac) + 2;
    endfunction

endpackage

// File: rtl/core/rotate_fit_coordinate_mapper_top.sv
// top level of the rotate-fit coordinate mapper
// input passes through the front stages, the divider stages and the back stages to the output
// throughput: one transaction per cycle while the output is not stalled; the restoring divider stages set the depth
// a stall on the output holds every stage of the pipeline in place
// reset: pipeline valid bits cleared, all configuration registers zero (unit scale, zero offsets, no rotation)
`timescale 1ns / 1ps

module rotate_fit_coordinate_mapper_top
    import rfcm_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_FRAC_BITS,
    parameter int DIM_BITS        = DEF_DIM_BITS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2*COORD_W-1:0]   s_axis_tdata,  // coord_x, coord_y
    input  logic                   s_axis_tuser,  // command
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [2*COORD_W-1:0]   m_axis_tdata,  // out_x, out_y
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_BITS-1:0]    cfg_data
);

    localparam int A_W = dvd_width(DIM_BITS, COORD_FRAC_BITS);
    localparam int M_W = A_W - 1;
    localparam int D_W = DIM_BITS + 1;

    logic adv;

    rot_t                                     quarter_turns;
    logic signed [DIM_BITS+COORD_FRAC_BITS:0] wm1, hm1;
    logic [DIM_BITS+COORD_FRAC_BITS-1:0]      xmax, ymax;
    logic [DIM_BITS-1:0]                      num, den;
    logic signed [2*DIM_BITS:0]               offx, offy;

    logic           f_valid;
    tag_t           f_tag;
    logic [M_W-1:0] f_mag_x, f_mag_y;
    logic [D_W-1:0] f_div;

    logic           d_valid;
    tag_t           d_tag;
    logic [M_W-1:0] d_q_x, d_q_y;
    logic [D_W-1:0] d_rem_x, d_rem_y;

    logic signed [COORD_W-1:0] out_x, out_y;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    rfcm_cfg #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .quarter_turns (quarter_turns),
        .wm1           (wm1),
        .hm1           (hm1),
        .xmax          (xmax),
        .ymax          (ymax),
        .num           (num),
        .den           (den),
        .offx          (offx),
        .offy          (offy)
    );

    rfcm_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (s_axis_tvalid),
        .in_cmd        (cmd_t'(s_axis_tuser)),
        .in_x          ($signed(s_axis_tdata[COORD_W-1:0])),
        .in_y          ($signed(s_axis_tdata[2*COORD_W-1:COORD_W])),
        .quarter_turns (quarter_turns),
        .wm1           (wm1),
        .hm1           (hm1),
        .num           (num),
        .den           (den),
        .offx          (offx),
        .offy          (offy),
        .out_valid     (f_valid),
        .out_tag       (f_tag),
        .out_mag_x     (f_mag_x),
        .out_mag_y     (f_mag_y),
        .out_div       (f_div)
    );

    rfcm_div #(
        .M_W (M_W),
        .D_W (D_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_tag    (f_tag),
        .in_mag_x  (f_mag_x),
        .in_mag_y  (f_mag_y),
        .in_div    (f_div),
        .out_valid (d_valid),
        .out_tag   (d_tag),
        .out_q_x   (d_q_x),
        .out_q_y   (d_q_y),
        .out_rem_x (d_rem_x),
        .out_rem_y (d_rem_y)
    );

    rfcm_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (d_valid),
        .in_tag        (d_tag),
        .in_q_x        (d_q_x),
        .in_q_y        (d_q_y),
        .in_rem_x      (d_rem_x),
        .in_rem_y      (d_rem_y),
        .quarter_turns (quarter_turns),
        .wm1           (wm1),
        .hm1           (hm1),
        .xmax          (xmax),
        .ymax          (ymax),
        .out_valid     (m_axis_tvalid),
        .out_x         (out_x),
        .out_y         (out_y)
    );

    assign m_axis_tdata = {out_y, out_x};

endmodule

// File: rtl/core/rfcm_cfg.sv
// configuration registers and derived scale ratio and centering offsets
`timescale 1ns / 1ps

module rfcm_cfg
    import rfcm_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_FRAC_BITS,
    parameter int DIM_BITS        = DEF_DIM_BITS
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [DIM_BITS-1:0]                  cfg_data,
    output rot_t                                 quarter_turns,
    output logic signed [DIM_BITS+COORD_FRAC_BITS:0] wm1,
    output logic signed [DIM_BITS+COORD_FRAC_BITS:0] hm1,
    output logic [DIM_BITS+COORD_FRAC_BITS-1:0]  xmax,
    output logic [DIM_BITS+COORD_FRAC_BITS-1:0]  ymax,
    output logic [DIM_BITS-1:0]                  num,
    output logic [DIM_BITS-1:0]                  den,
    output logic signed [2*DIM_BITS:0]           offx,
    output logic signed [2*DIM_BITS:0]           offy
);

    localparam int W1_W  = DIM_BITS + COORD_FRAC_BITS + 1;
    localparam int XM_W  = DIM_BITS + COORD_FRAC_BITS;
    localparam int PR_W  = 2 * DIM_BITS;
    localparam int OFF_W = 2 * DIM_BITS + 1;

    logic [DIM_BITS-1:0] nw_reg, nh_reg, vw_reg, vh_reg, tol_reg;
    rot_t                qt_reg;
    logic                crop_reg;

    logic [DIM_BITS-1:0] rw, rh;
    logic                swap, unset, trim, pick_x, special_next;
    logic [PR_W-1:0]     pxr, pyr;
    logic [DIM_BITS-1:0] num_next, den_next;
    logic [DIM_BITS-1:0] num_reg, den_reg;
    logic                special_reg;
    logic [PR_W-1:0]     nwd, rwn, nhd, rhn;
    logic signed [OFF_W-1:0] offx_next, offy_next, offx_reg, offy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nw_reg   <= '0;
            nh_reg   <= '0;
            vw_reg   <= '0;
            vh_reg   <= '0;
            tol_reg  <= '0;
            qt_reg   <= ROT_0;
            crop_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NATIVE_WIDTH:   nw_reg   <= cfg_data;
                REG_NATIVE_HEIGHT:  nh_reg   <= cfg_data;
                REG_VIDEO_WIDTH:    vw_reg   <= cfg_data;
                REG_VIDEO_HEIGHT:   vh_reg   <= cfg_data;
                REG_QUARTER_TURNS:  qt_reg   <= rot_t'(cfg_data[1:0]);
                REG_CROP_MODE:      crop_reg <= cfg_data[0];
                REG_TRIM_TOLERANCE: tol_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        swap  = (qt_reg == ROT_90) || (qt_reg == ROT_270);
        rw    = swap ? vh_reg : vw_reg;
        rh    = swap ? vw_reg : vh_reg;
        unset = (nw_reg == '0) || (nh_reg == '0) || (vw_reg == '0) || (vh_reg == '0);
        // unrotated full-width video at most the trim tolerance of rows shorter than the screen stays 1:1
        trim  = (qt_reg == ROT_0) && (rw == nw_reg) && (rh < nh_reg) &&
                ((nh_reg - rh) <= tol_reg);
        pxr   = PR_W'(nw_reg) * PR_W'(rh);
        pyr   = PR_W'(nh_reg) * PR_W'(rw);
        pick_x = crop_reg ? (pxr >= pyr) : (pxr <= pyr);
        special_next = unset || trim;
        if (special_next)
        begin
            num_next = DIM_BITS'(1);
            den_next = DIM_BITS'(1);
        end
        else
        begin
            num_next = pick_x ? nw_reg : nh_reg;
            den_next = pick_x ? rw : rh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg     <= DIM_BITS'(1);
            den_reg     <= DIM_BITS'(1);
            special_reg <= 1'b1;
        end
        else
        begin
            num_reg     <= num_next;
            den_reg     <= den_next;
            special_reg <= special_next;
        end
    end

    // offsets kept in units of 1/(2*den) pixel
    always_comb
    begin
        nwd = PR_W'(nw_reg) * PR_W'(den_reg);
        rwn = PR_W'(rw) * PR_W'(num_reg);
        nhd = PR_W'(nh_reg) * PR_W'(den_reg);
        rhn = PR_W'(rh) * PR_W'(num_reg);
        if (special_reg)
        begin
            offx_next = '0;
            offy_next = '0;
        end
        else
        begin
            offx_next = $signed({1'b0, nwd}) - $signed({1'b0, rwn});
            offy_next = $signed({1'b0, nhd}) - $signed({1'b0, rhn});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offx_reg <= '0;
            offy_reg <= '0;
        end
        else
        begin
            offx_reg <= offx_next;
            offy_reg <= offy_next;
        end
    end

    assign quarter_turns = qt_reg;
    assign wm1  = $signed((W1_W'(vw_reg) - W1_W'(1)) << COORD_FRAC_BITS);
    assign hm1  = $signed((W1_W'(vh_reg) - W1_W'(1)) << COORD_FRAC_BITS);
    assign xmax = (vw_reg == '0) ? '0 : ((XM_W'(vw_reg) - XM_W'(1)) << COORD_FRAC_BITS);
    assign ymax = (vh_reg == '0) ? '0 : ((XM_W'(vh_reg) - XM_W'(1)) << COORD_FRAC_BITS);
    assign num  = num_reg;
    assign den  = den_reg;
    assign offx = offx_reg;
    assign offy = offy_reg;

endmodule

// File: rtl/core/rfcm_front.sv
// input capture, forward rotation, scaling multiply and dividend build
`timescale 1ns / 1ps

module rfcm_front
    import rfcm_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_FRAC_BITS,
    parameter int DIM_BITS        = DEF_DIM_BITS
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  cmd_t                                 in_cmd,
    input  logic signed [COORD_W-1:0]            in_x,
    input  logic signed [COORD_W-1:0]            in_y,
    input  rot_t                                 quarter_turns,
    input  logic signed [DIM_BITS+COORD_FRAC_BITS:0] wm1,
    input  logic signed [DIM_BITS+COORD_FRAC_BITS:0] hm1,
    input  logic [DIM_BITS-1:0]                  num,
    input  logic [DIM_BITS-1:0]                  den,
    input  logic signed [2*DIM_BITS:0]           offx,
    input  logic signed [2*DIM_BITS:0]           offy,
    output logic                                 out_valid,
    output tag_t                                 out_tag,
    output logic [dvd_width(DIM_BITS, COORD_FRAC_BITS)-2:0] out_mag_x,
    output logic [dvd_width(DIM_BITS, COORD_FRAC_BITS)-2:0] out_mag_y,
    output logic [DIM_BITS:0]                    out_div
);

    localparam int V_W = rot_width(DIM_BITS, COORD_FRAC_BITS);
    localparam int P_W = V_W + DIM_BITS + 1;
    localparam int A_W = dvd_width(DIM_BITS, COORD_FRAC_BITS);
    localparam int M_W = A_W - 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    cmd_t cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;
    logic signed [COORD_W-1:0] x1_reg, y1_reg;
    logic signed [V_W-1:0]     vx_next, vy_next, vx2_reg, vy2_reg;
    logic [DIM_BITS-1:0]       mul, dd3_reg, dd4_reg;
    logic signed [P_W-1:0]     px_next, py_next, px3_reg, py3_reg;
    logic signed [A_W-1:0]     ax_next, ay_next, ax4_reg, ay4_reg;
    logic signed [A_W-1:0]     offx_term, offy_term;
    logic [M_W-1:0]            mx5_reg, my5_reg;
    tag_t                      tag5_reg;
    logic [DIM_BITS:0]         div5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // forward direction rotates first, inverse rotates after the divide
    always_comb
    begin
        if (cmd1_reg == CMD_TO_VIDEO)
        begin
            vx_next = V_W'(x1_reg);
            vy_next = V_W'(y1_reg);
        end
        else
        begin
            unique case (quarter_turns)
                ROT_90:
                begin
                    vx_next = V_W'(hm1) - V_W'(y1_reg);
                    vy_next = V_W'(x1_reg);
                end
                ROT_180:
                begin
                    vx_next = V_W'(wm1) - V_W'(x1_reg);
                    vy_next = V_W'(hm1) - V_W'(y1_reg);
                end
                ROT_270:
                begin
                    vx_next = V_W'(y1_reg);
                    vy_next = V_W'(wm1) - V_W'(x1_reg);
                end
                default:
                begin
                    vx_next = V_W'(x1_reg);
                    vy_next = V_W'(y1_reg);
                end
            endcase
        end
    end

    always_comb
    begin
        mul     = (cmd2_reg == CMD_TO_VIDEO) ? den : num;
        px_next = vx2_reg * $signed({1'b0, mul});
        py_next = vy2_reg * $signed({1'b0, mul});
    end

    // rounding dividend: 2*v*mul +/- off*one + divisor/2
    always_comb
    begin
        offx_term = A_W'(offx) <<< COORD_FRAC_BITS;
        offy_term = A_W'(offy) <<< COORD_FRAC_BITS;
        if (cmd3_reg == CMD_TO_VIDEO)
        begin
            ax_next = (A_W'(px3_reg) <<< 1) - offx_term + $signed(A_W'(dd3_reg));
            ay_next = (A_W'(py3_reg) <<< 1) - offy_term + $signed(A_W'(dd3_reg));
        end
        else
        begin
            ax_next = (A_W'(px3_reg) <<< 1) + offx_term + $signed(A_W'(dd3_reg));
            ay_next = (A_W'(py3_reg) <<< 1) + offy_term + $signed(A_W'(dd3_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= in_cmd;
            x1_reg   <= in_x;
            y1_reg   <= in_y;

            cmd2_reg <= cmd1_reg;
            vx2_reg  <= vx_next;
            vy2_reg  <= vy_next;

            cmd3_reg <= cmd2_reg;
            px3_reg  <= px_next;
            py3_reg  <= py_next;
            dd3_reg  <= (cmd2_reg == CMD_TO_VIDEO) ? num : den;

            cmd4_reg <= cmd3_reg;
            ax4_reg  <= ax_next;
            ay4_reg  <= ay_next;
            dd4_reg  <= dd3_reg;

            tag5_reg.cmd   <= cmd4_reg;
            tag5_reg.neg_x <= ax4_reg[A_W-1];
            tag5_reg.neg_y <= ay4_reg[A_W-1];
            mx5_reg  <= ax4_reg[A_W-1] ? M_W'(-ax4_reg) : M_W'(ax4_reg);
            my5_reg  <= ay4_reg[A_W-1] ? M_W'(-ay4_reg) : M_W'(ay4_reg);
            div5_reg <= {dd4_reg, 1'b0};
        end
    end

    assign out_valid = v5_reg;
    assign out_tag   = tag5_reg;
    assign out_mag_x = mx5_reg;
    assign out_mag_y = my5_reg;
    assign out_div   = div5_reg;

endmodule

// File: rtl/core/rfcm_div.sv
// two-lane restoring divider, one quotient bit per pipeline stage
`timescale 1ns / 1ps

module rfcm_div
    import rfcm_pkg::*;
#(
    parameter int M_W = 40,
    parameter int D_W = DEF_DIM_BITS + 1
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  tag_t           in_tag,
    input  logic [M_W-1:0] in_mag_x,
    input  logic [M_W-1:0] in_mag_y,
    input  logic [D_W-1:0] in_div,
    output logic           out_valid,
    output tag_t           out_tag,
    output logic [M_W-1:0] out_q_x,
    output logic [M_W-1:0] out_q_y,
    output logic [D_W-1:0] out_rem_x,
    output logic [D_W-1:0] out_rem_y
);

    localparam int STAGES = M_W;
    localparam int LANES  = 2;

    logic           valid_reg [STAGES];
    tag_t           tag_reg   [STAGES];
    logic [D_W-1:0] div_reg   [STAGES];
    logic [M_W-1:0] num_reg   [STAGES][LANES];
    logic [M_W-1:0] q_reg     [STAGES][LANES];
    logic [D_W-1:0] rem_reg   [STAGES][LANES];

    logic [D_W-1:0] div_cur   [STAGES];
    logic [M_W-1:0] num_cur   [STAGES][LANES];
    logic [M_W-1:0] q_cur     [STAGES][LANES];
    logic [D_W-1:0] rem_cur   [STAGES][LANES];
    logic [M_W-1:0] num_next  [STAGES][LANES];
    logic [M_W-1:0] q_next    [STAGES][LANES];
    logic [D_W-1:0] rem_next  [STAGES][LANES];

    always_comb
    begin
        logic [D_W:0] trial;
        logic         fits;
        div_cur[0]    = in_div;
        num_cur[0][0] = in_mag_x;
        num_cur[0][1] = in_mag_y;
        for (int l = 0; l < LANES; l++)
        begin
            q_cur[0][l]   = '0;
            rem_cur[0][l] = '0;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            div_cur[k] = div_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                num_cur[k][l] = num_reg[k-1][l];
                q_cur[k][l]   = q_reg[k-1][l];
                rem_cur[k][l] = rem_reg[k-1][l];
            end
        end
        for (int k = 0; k < STAGES; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_cur[k][l], num_cur[k][l][M_W-1]};
                fits  = trial >= {1'b0, div_cur[k]};
                rem_next[k][l] = fits ? D_W'(trial - {1'b0, div_cur[k]}) : D_W'(trial);
                q_next[k][l]   = {q_cur[k][l][M_W-2:0], fits};
                num_next[k][l] = num_cur[k][l] << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= in_tag;
            for (int k = 1; k < STAGES; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
            for (int k = 0; k < STAGES; k++)
            begin
                div_reg[k] <= div_cur[k];
                for (int l = 0; l < LANES; l++)
                begin
                    num_reg[k][l] <= num_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                    rem_reg[k][l] <= rem_next[k][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];
    assign out_q_x   = q_reg[STAGES-1][0];
    assign out_q_y   = q_reg[STAGES-1][1];
    assign out_rem_x = rem_reg[STAGES-1][0];
    assign out_rem_y = rem_reg[STAGES-1][1];

endmodule

// File: rtl/core/rfcm_back.sv
// floor fix-up, inverse rotation, clamp and saturation into the output register
`timescale 1ns / 1ps

module rfcm_back
    import rfcm_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_FRAC_BITS,
    parameter int DIM_BITS        = DEF_DIM_BITS
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  tag_t                                 in_tag,
    input  logic [dvd_width(DIM_BITS, COORD_FRAC_BITS)-2:0] in_q_x,
    input  logic [dvd_width(DIM_BITS, COORD_FRAC_BITS)-2:0] in_q_y,
    input  logic [DIM_BITS:0]                    in_rem_x,
    input  logic [DIM_BITS:0]                    in_rem_y,
    input  rot_t                                 quarter_turns,
    input  logic signed [DIM_BITS+COORD_FRAC_BITS:0] wm1,
    input  logic signed [DIM_BITS+COORD_FRAC_BITS:0] hm1,
    input  logic [DIM_BITS+COORD_FRAC_BITS-1:0]  xmax,
    input  logic [DIM_BITS+COORD_FRAC_BITS-1:0]  ymax,
    output logic                                 out_valid,
    output logic signed [COORD_W-1:0]            out_x,
    output logic signed [COORD_W-1:0]            out_y
);

    localparam int A_W = dvd_width(DIM_BITS, COORD_FRAC_BITS);
    localparam int R_W = A_W + 1;
    localparam logic signed [R_W-1:0] SAT_HI = R_W'(2 ** (COORD_W - 1) - 1);
    localparam logic signed [R_W-1:0] SAT_LO = R_W'(-(2 ** (COORD_W - 1)));

    logic v1_reg, v2_reg, v3_reg;
    cmd_t cmd1_reg, cmd2_reg;
    logic signed [A_W-1:0] qx_next, qy_next, qx1_reg, qy1_reg;
    logic signed [R_W-1:0] rx_next, ry_next, rx2_reg, ry2_reg;
    logic signed [R_W-1:0] cx, cy, xmax_s, ymax_s;
    logic signed [COORD_W-1:0] ox_next, oy_next, ox_reg, oy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // negative dividend: floor is minus the ceiling of the magnitude quotient
    always_comb
    begin
        if (in_tag.neg_x)
            qx_next = -($signed(A_W'(in_q_x)) + $signed(A_W'(in_rem_x != '0)));
        else
            qx_next = $signed(A_W'(in_q_x));
        if (in_tag.neg_y)
            qy_next = -($signed(A_W'(in_q_y)) + $signed(A_W'(in_rem_y != '0)));
        else
            qy_next = $signed(A_W'(in_q_y));
    end

    always_comb
    begin
        if (cmd1_reg == CMD_TO_NATIVE)
        begin
            rx_next = R_W'(qx1_reg);
            ry_next = R_W'(qy1_reg);
        end
        else
        begin
            unique case (quarter_turns)
                ROT_90:
                begin
                    rx_next = R_W'(qy1_reg);
                    ry_next = R_W'(hm1) - R_W'(qx1_reg);
                end
                ROT_180:
                begin
                    rx_next = R_W'(wm1) - R_W'(qx1_reg);
                    ry_next = R_W'(hm1) - R_W'(qy1_reg);
                end
                ROT_270:
                begin
                    rx_next = R_W'(wm1) - R_W'(qy1_reg);
                    ry_next = R_W'(qx1_reg);
                end
                default:
                begin
                    rx_next = R_W'(qx1_reg);
                    ry_next = R_W'(qy1_reg);
                end
            endcase
        end
    end

    always_comb
    begin
        xmax_s = $signed(R_W'(xmax));
        ymax_s = $signed(R_W'(ymax));
        cx = rx2_reg;
        cy = ry2_reg;
        if (cmd2_reg == CMD_TO_VIDEO)
        begin
            if (rx2_reg < 0)
                cx = '0;
            else if (rx2_reg > xmax_s)
                cx = xmax_s;
            if (ry2_reg < 0)
                cy = '0;
            else if (ry2_reg > ymax_s)
                cy = ymax_s;
        end
        if (cx > SAT_HI)
            ox_next = COORD_W'(SAT_HI);
        else if (cx < SAT_LO)
            ox_next = COORD_W'(SAT_LO);
        else
            ox_next = COORD_W'(cx);
        if (cy > SAT_HI)
            oy_next = COORD_W'(SAT_HI);
        else if (cy < SAT_LO)
            oy_next = COORD_W'(SAT_LO);
        else
            oy_next = COORD_W'(cy);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= in_tag.cmd;
            qx1_reg  <= qx_next;
            qy1_reg  <= qy_next;
            cmd2_reg <= cmd1_reg;
            rx2_reg  <= rx_next;
            ry2_reg  <= ry_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;

endmodule
